/* rtl/tle_pkg.sv */
// Shared types, character codes and microcode table of the terminal line editor.
package tle_pkg;

	localparam int PC_W = 6;
	typedef logic [PC_W-1:0] pc_t;

	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_D      = 8'h44;
	localparam logic [7:0] CH_LBRK   = 8'h5B;
	localparam logic [7:0] CH_TILDE  = 8'h7E;
	localparam logic [7:0] CH_DEL    = 8'h7F;

	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_ESC    = 2'd1;
	localparam logic [1:0] MODE_CSI    = 2'd2;

	// jump conditions
	localparam logic [3:0] C_NONE       = 4'd0;
	localparam logic [3:0] C_ALWAYS     = 4'd1;
	localparam logic [3:0] C_MODE_ESC   = 4'd2;
	localparam logic [3:0] C_MODE_CSI   = 4'd3;
	localparam logic [3:0] C_IS_ESC     = 4'd4;
	localparam logic [3:0] C_IS_NL      = 4'd5;
	localparam logic [3:0] C_IS_BS      = 4'd6;
	localparam logic [3:0] C_PRINT_ROOM = 4'd7;
	localparam logic [3:0] C_CSI_D_OK   = 4'd8;
	localparam logic [3:0] C_CSI_C_OK   = 4'd9;
	localparam logic [3:0] C_J_GE_LEN   = 4'd10;
	localparam logic [3:0] C_RD_NOT_SP  = 4'd11;
	localparam logic [3:0] C_CUR_ZERO   = 4'd12;
	localparam logic [3:0] C_J1_GE_LEN  = 4'd13;
	localparam logic [3:0] C_J_GT_LEN   = 4'd14;
	localparam logic [3:0] C_J_LE_CUR   = 4'd15;

	localparam logic [1:0] E_NONE  = 2'd0;
	localparam logic [1:0] E_CONST = 2'd1;
	localparam logic [1:0] E_C     = 2'd2;
	localparam logic [1:0] E_RD    = 2'd3;

	localparam logic [2:0] J_HOLD  = 3'd0;
	localparam logic [2:0] J_ZERO  = 3'd1;
	localparam logic [2:0] J_CUR   = 3'd2;
	localparam logic [2:0] J_CURM1 = 3'd3;
	localparam logic [2:0] J_LEN   = 3'd4;
	localparam logic [2:0] J_INC   = 3'd5;
	localparam logic [2:0] J_DEC   = 3'd6;

	localparam logic [1:0] M_NONE = 2'd0;
	localparam logic [1:0] M_RD   = 2'd1;
	localparam logic [1:0] M_WR   = 2'd2;

	localparam logic [1:0] A_J   = 2'd0;
	localparam logic [1:0] A_J1  = 2'd1;
	localparam logic [1:0] A_JM1 = 2'd2;
	localparam logic [1:0] A_CUR = 2'd3;

	localparam logic W_RD = 1'b0;
	localparam logic W_C  = 1'b1;

	localparam logic [3:0] R_NONE    = 4'd0;
	localparam logic [3:0] R_INS     = 4'd1;
	localparam logic [3:0] R_DEL     = 4'd2;
	localparam logic [3:0] R_CLR     = 4'd3;
	localparam logic [3:0] R_CURINC  = 4'd4;
	localparam logic [3:0] R_CURDEC  = 4'd5;
	localparam logic [3:0] R_MESC    = 4'd6;
	localparam logic [3:0] R_MNORM   = 4'd7;
	localparam logic [3:0] R_MFROMC  = 4'd8;

	typedef struct packed {
		logic [3:0] cond;
		pc_t        target;
		logic [1:0] esrc;
		logic [7:0] ebyte;
		logic       echan;
		logic [2:0] jop;
		logic [1:0] mop;
		logic [1:0] asel;
		logic       wsel;
		logic [3:0] rop;
		logic       fin;
	} ucw_t;

	typedef struct packed {
		logic mode_esc;
		logic mode_csi;
		logic is_esc;
		logic is_nl;
		logic is_bs;
		logic print_room;
		logic csi_d_ok;
		logic csi_c_ok;
		logic j_ge_len;
		logic rd_not_sp;
		logic cur_zero;
		logic j1_ge_len;
		logic j_gt_len;
		logic j_le_cur;
	} flags_t;

	localparam pc_t P_IDLE   = 6'd0;
	localparam pc_t P_DISP   = 6'd1;
	localparam pc_t P_ESC    = 6'd8;
	localparam pc_t P_SETESC = 6'd9;
	localparam pc_t P_CSI    = 6'd10;
	localparam pc_t P_CSIL   = 6'd13;
	localparam pc_t P_CSIR   = 6'd16;
	localparam pc_t P_NL     = 6'd19;
	localparam pc_t P_NLSK   = 6'd20;
	localparam pc_t P_NLOUT  = 6'd23;
	localparam pc_t P_NLEND  = 6'd25;
	localparam pc_t P_BS     = 6'd27;
	localparam pc_t P_BSSH   = 6'd29;
	localparam pc_t P_BSE    = 6'd31;
	localparam pc_t P_BST    = 6'd34;
	localparam pc_t P_BSS    = 6'd36;
	localparam pc_t P_BSL    = 6'd37;
	localparam pc_t P_INS    = 6'd41;
	localparam pc_t P_INSH   = 6'd42;
	localparam pc_t P_INSW   = 6'd44;
	localparam pc_t P_INST   = 6'd46;
	localparam pc_t P_INSL0  = 6'd48;
	localparam pc_t P_INSL   = 6'd49;
	localparam pc_t P_DONE   = 6'd53;

	function automatic ucw_t ucode(input pc_t pc);
		ucw_t w;
		w = '0;
		case (pc)
			P_IDLE: begin end
			6'd1: begin w.cond = C_MODE_ESC; w.target = P_ESC; end
			6'd2: begin w.cond = C_MODE_CSI; w.target = P_CSI; end
			6'd3: begin w.cond = C_IS_ESC; w.target = P_SETESC; end
			6'd4: begin w.cond = C_IS_NL; w.target = P_NL; end
			6'd5: begin w.cond = C_IS_BS; w.target = P_BS; end
			6'd6: begin w.cond = C_PRINT_ROOM; w.target = P_INS; end
			6'd7: begin w.cond = C_ALWAYS; w.target = P_DONE; end
			// escape handling
			6'd8: begin w.rop = R_MFROMC; w.cond = C_ALWAYS; w.target = P_DONE; end
			6'd9: begin w.rop = R_MESC; w.cond = C_ALWAYS; w.target = P_DONE; end
			6'd10: begin w.rop = R_MNORM; w.cond = C_CSI_D_OK; w.target = P_CSIL; end
			6'd11: begin w.cond = C_CSI_C_OK; w.target = P_CSIR; end
			6'd12: begin w.cond = C_ALWAYS; w.target = P_DONE; end
			6'd13: begin w.esrc = E_CONST; w.ebyte = CH_ESC; end
			6'd14: begin w.esrc = E_CONST; w.ebyte = CH_LBRK; end
			6'd15: begin
				w.esrc = E_CONST; w.ebyte = CH_D; w.rop = R_CURDEC;
				w.cond = C_ALWAYS; w.target = P_DONE;
			end
			6'd16: begin w.esrc = E_CONST; w.ebyte = CH_ESC; end
			6'd17: begin w.esrc = E_CONST; w.ebyte = CH_LBRK; end
			6'd18: begin
				w.esrc = E_CONST; w.ebyte = CH_C; w.rop = R_CURINC;
				w.cond = C_ALWAYS; w.target = P_DONE;
			end
			// line end: newline, line without leading spaces, prompt
			6'd19: begin w.esrc = E_CONST; w.ebyte = CH_LF; w.jop = J_ZERO; end
			6'd20: begin w.mop = M_RD; w.asel = A_J; w.cond = C_J_GE_LEN; w.target = P_NLEND; end
			6'd21: begin w.cond = C_RD_NOT_SP; w.target = P_NLOUT; end
			6'd22: begin w.jop = J_INC; w.cond = C_ALWAYS; w.target = P_NLSK; end
			6'd23: begin w.mop = M_RD; w.asel = A_J; w.cond = C_J_GE_LEN; w.target = P_NLEND; end
			6'd24: begin
				w.esrc = E_RD; w.echan = 1'b1; w.jop = J_INC;
				w.cond = C_ALWAYS; w.target = P_NLOUT;
			end
			6'd25: begin w.esrc = E_CONST; w.ebyte = CH_DOLLAR; w.rop = R_CLR; end
			6'd26: begin w.esrc = E_CONST; w.ebyte = CH_SP; w.cond = C_ALWAYS; w.target = P_DONE; end
			// backspace
			6'd27: begin w.cond = C_CUR_ZERO; w.target = P_DONE; end
			6'd28: begin w.jop = J_CURM1; end
			6'd29: begin w.mop = M_RD; w.asel = A_J1; w.cond = C_J1_GE_LEN; w.target = P_BSE; end
			6'd30: begin
				w.mop = M_WR; w.asel = A_J; w.wsel = W_RD; w.jop = J_INC;
				w.cond = C_ALWAYS; w.target = P_BSSH;
			end
			6'd31: begin w.esrc = E_CONST; w.ebyte = CH_BS; w.rop = R_DEL; end
			6'd32: begin w.esrc = E_CONST; w.ebyte = CH_SP; end
			6'd33: begin w.esrc = E_CONST; w.ebyte = CH_BS; w.jop = J_CUR; end
			6'd34: begin w.mop = M_RD; w.asel = A_J; w.cond = C_J_GE_LEN; w.target = P_BSS; end
			6'd35: begin w.esrc = E_RD; w.jop = J_INC; w.cond = C_ALWAYS; w.target = P_BST; end
			6'd36: begin w.esrc = E_CONST; w.ebyte = CH_SP; w.jop = J_CUR; end
			6'd37: begin w.cond = C_J_GT_LEN; w.target = P_DONE; end
			6'd38: begin w.esrc = E_CONST; w.ebyte = CH_ESC; end
			6'd39: begin w.esrc = E_CONST; w.ebyte = CH_LBRK; end
			6'd40: begin
				w.esrc = E_CONST; w.ebyte = CH_D; w.jop = J_INC;
				w.cond = C_ALWAYS; w.target = P_BSL;
			end
			// printable insert
			6'd41: begin w.jop = J_LEN; end
			6'd42: begin w.mop = M_RD; w.asel = A_JM1; w.cond = C_J_LE_CUR; w.target = P_INSW; end
			6'd43: begin
				w.mop = M_WR; w.asel = A_J; w.wsel = W_RD; w.jop = J_DEC;
				w.cond = C_ALWAYS; w.target = P_INSH;
			end
			6'd44: begin
				w.mop = M_WR; w.asel = A_CUR; w.wsel = W_C; w.rop = R_INS;
				w.esrc = E_C;
			end
			6'd45: begin w.jop = J_CUR; end
			6'd46: begin w.mop = M_RD; w.asel = A_J; w.cond = C_J_GE_LEN; w.target = P_INSL0; end
			6'd47: begin w.esrc = E_RD; w.jop = J_INC; w.cond = C_ALWAYS; w.target = P_INST; end
			6'd48: begin w.jop = J_CUR; end
			6'd49: begin w.cond = C_J_GE_LEN; w.target = P_DONE; end
			6'd50: begin w.esrc = E_CONST; w.ebyte = CH_ESC; end
			6'd51: begin w.esrc = E_CONST; w.ebyte = CH_LBRK; end
			6'd52: begin
				w.esrc = E_CONST; w.ebyte = CH_D; w.jop = J_INC;
				w.cond = C_ALWAYS; w.target = P_INSL;
			end
			P_DONE: begin w.fin = 1'b1; end
			default: begin w.fin = 1'b1; end
		endcase
		return w;
	endfunction

endpackage

/* rtl/tle_dp.sv */
// Datapath: line memory, length, cursor, index, escape mode and jump flags.
module tle_dp #(
	parameter int LINE_CAPACITY = 16,
	localparam int LW = $clog2(LINE_CAPACITY),
	localparam int JW = LW + 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  logic [7:0]      rx_byte,
	input  logic            step,
	input  tle_pkg::ucw_t   ctl,
	output tle_pkg::flags_t flags,
	output logic [7:0]      emit_data
);

	logic [7:0]    mem [LINE_CAPACITY];
	logic [7:0]    c_q;
	logic [7:0]    rd_q;
	logic [1:0]    mode_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] cur_q;
	logic [JW-1:0] j_q;
	logic [JW-1:0] j_nx;
	logic [JW-1:0] j_p1;
	logic [JW-1:0] j_m1;
	logic [JW-1:0] len_x;
	logic [JW-1:0] cur_x;
	logic [LW-1:0] addr;
	logic [7:0]    wdata;

	assign len_x = {1'b0, len_q};
	assign cur_x = {1'b0, cur_q};
	assign j_p1  = j_q + JW'(1);
	assign j_m1  = j_q - JW'(1);

	always_comb begin
		case (ctl.asel)
			tle_pkg::A_J:   addr = j_q[LW-1:0];
			tle_pkg::A_J1:  addr = j_p1[LW-1:0];
			tle_pkg::A_JM1: addr = j_m1[LW-1:0];
			default:        addr = cur_q;
		endcase
	end

	assign wdata = (ctl.wsel == tle_pkg::W_C) ? c_q : rd_q;

	always_comb begin
		case (ctl.jop)
			tle_pkg::J_ZERO:  j_nx = '0;
			tle_pkg::J_CUR:   j_nx = cur_x;
			tle_pkg::J_CURM1: j_nx = cur_x - JW'(1);
			tle_pkg::J_LEN:   j_nx = len_x;
			tle_pkg::J_INC:   j_nx = j_p1;
			tle_pkg::J_DEC:   j_nx = j_m1;
			default:          j_nx = j_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (step && ctl.mop == tle_pkg::M_WR)
			mem[addr] <= wdata;
		if (step && ctl.mop == tle_pkg::M_RD)
			rd_q <= mem[addr];
		if (load)
			c_q <= rx_byte;
		if (step)
			j_q <= j_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= tle_pkg::MODE_NORMAL;
			len_q  <= '0;
			cur_q  <= '0;
		end else if (step) begin
			case (ctl.rop)
				tle_pkg::R_INS: begin
					len_q <= len_q + LW'(1);
					cur_q <= cur_q + LW'(1);
				end
				tle_pkg::R_DEL: begin
					len_q <= len_q - LW'(1);
					cur_q <= cur_q - LW'(1);
				end
				tle_pkg::R_CLR: begin
					len_q <= '0;
					cur_q <= '0;
				end
				tle_pkg::R_CURINC: cur_q <= cur_q + LW'(1);
				tle_pkg::R_CURDEC: cur_q <= cur_q - LW'(1);
				tle_pkg::R_MESC:   mode_q <= tle_pkg::MODE_ESC;
				tle_pkg::R_MNORM:  mode_q <= tle_pkg::MODE_NORMAL;
				tle_pkg::R_MFROMC: mode_q <= (c_q == tle_pkg::CH_LBRK) ?
					tle_pkg::MODE_CSI : tle_pkg::MODE_NORMAL;
				default: begin end
			endcase
		end
	end

	always_comb begin
		flags.mode_esc   = (mode_q == tle_pkg::MODE_ESC);
		flags.mode_csi   = (mode_q == tle_pkg::MODE_CSI);
		flags.is_esc     = (c_q == tle_pkg::CH_ESC);
		flags.is_nl      = (c_q == tle_pkg::CH_CR) || (c_q == tle_pkg::CH_LF);
		flags.is_bs      = (c_q == tle_pkg::CH_DEL) || (c_q == tle_pkg::CH_BS);
		flags.print_room = (c_q inside {[tle_pkg::CH_SP:tle_pkg::CH_TILDE]}) &&
			(len_q < LW'(LINE_CAPACITY - 1));
		flags.csi_d_ok   = (c_q == tle_pkg::CH_D) && (cur_q != '0);
		flags.csi_c_ok   = (c_q == tle_pkg::CH_C) && (cur_q < len_q);
		flags.j_ge_len   = (j_q >= len_x);
		flags.rd_not_sp  = (rd_q != tle_pkg::CH_SP);
		flags.cur_zero   = (cur_q == '0);
		flags.j1_ge_len  = (j_p1 >= len_x);
		flags.j_gt_len   = (j_q > len_x);
		flags.j_le_cur   = (j_q <= cur_x);
	end

	always_comb begin
		case (ctl.esrc)
			tle_pkg::E_C:  emit_data = c_q;
			tle_pkg::E_RD: emit_data = rd_q;
			default:       emit_data = ctl.ebyte;
		endcase
	end

endmodule

/* rtl/tle_emit.sv */
// Output stage: one held-back byte so the final one of a burst carries tlast.
module tle_emit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       emit_req,
	input  logic [7:0] emit_byte,
	input  logic       emit_chan,
	input  logic       flush,
	output logic       stall,
	output logic       pend_v,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tuser,
	output logic       m_tlast
);

	logic       pend_v_q;
	logic [7:0] pend_byte_q;
	logic       pend_chan_q;
	logic       out_v_q;
	logic [7:0] out_byte_q;
	logic       out_chan_q;
	logic       out_last_q;
	logic       push;
	logic       slot_free;
	logic       adv;

	assign push      = (emit_req || flush) && pend_v_q;
	assign slot_free = !out_v_q || m_tready;
	assign stall     = push && !slot_free;
	assign adv       = (emit_req || flush) && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (push && slot_free)
				out_v_q <= 1'b1;
			else if (m_tready)
				out_v_q <= 1'b0;
			if (adv)
				pend_v_q <= emit_req;
		end
	end

	always_ff @(posedge clk) begin
		if (push && slot_free) begin
			out_byte_q <= pend_byte_q;
			out_chan_q <= pend_chan_q;
			out_last_q <= flush;
		end
		if (adv && emit_req) begin
			pend_byte_q <= emit_byte;
			pend_chan_q <= emit_chan;
		end
	end

	assign pend_v   = pend_v_q;
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_chan_q;
	assign m_tlast  = out_last_q;

endmodule

/* rtl/terminal_line_editor.sv */
// Terminal line editor top level: microcode sequencer, datapath and output stage.
//
// Input stream: one received terminal byte per transfer on s_tdata. Output stream:
// echo and command-line bytes on m_tdata, m_tuser 1 for command-line bytes, m_tlast
// on the final byte caused by one input byte. Bytes that cause no output (escape
// prefixes, ignored controls, a full line) give no transfer at all.
// A byte is taken only while the sequencer is idle; it then runs a microprogram at
// one control step per cycle unless stalled by the output. After dispatch steps on
// the byte, it shifts, redraws or sends characters on the command channel, skips
// leading spaces, emits cursor-left sequences and other bytes, and ends with a
// final step that releases the held byte with tlast.
// An emitted byte waits in a holding register until the next emit step or the final
// step moves it to the output register, so it appears in the cycle after that step.
// When the receiver stalls, the sequencer halts on the next emit or final step that
// finds the output register full; the held byte and the output register keep their
// contents. The next input byte is taken while the last result still waits in the
// output register.
// Reset clears the escape mode, line length and cursor, and returns to idle; the line
// memory needs no clearing since only written entries are used.
module terminal_line_editor #(
	parameter int LINE_CAPACITY = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tuser,   // [0] channel
	output logic       m_tlast
);

	tle_pkg::pc_t    pc_q;
	tle_pkg::ucw_t   ctl;
	tle_pkg::flags_t flags;
	logic            busy;
	logic            load;
	logic            stall;
	logic            step;
	logic            take;
	logic            pend_v;
	logic [7:0]      emit_data;

	assign busy     = (pc_q != tle_pkg::P_IDLE);
	assign s_tready = !busy;
	assign load     = s_tvalid && s_tready;
	assign ctl      = tle_pkg::ucode(pc_q);
	assign step     = busy && !stall;

	always_comb begin
		case (ctl.cond)
			tle_pkg::C_ALWAYS:     take = 1'b1;
			tle_pkg::C_MODE_ESC:   take = flags.mode_esc;
			tle_pkg::C_MODE_CSI:   take = flags.mode_csi;
			tle_pkg::C_IS_ESC:     take = flags.is_esc;
			tle_pkg::C_IS_NL:      take = flags.is_nl;
			tle_pkg::C_IS_BS:      take = flags.is_bs;
			tle_pkg::C_PRINT_ROOM: take = flags.print_room;
			tle_pkg::C_CSI_D_OK:   take = flags.csi_d_ok;
			tle_pkg::C_CSI_C_OK:   take = flags.csi_c_ok;
			tle_pkg::C_J_GE_LEN:   take = flags.j_ge_len;
			tle_pkg::C_RD_NOT_SP:  take = flags.rd_not_sp;
			tle_pkg::C_CUR_ZERO:   take = flags.cur_zero;
			tle_pkg::C_J1_GE_LEN:  take = flags.j1_ge_len;
			tle_pkg::C_J_GT_LEN:   take = flags.j_gt_len;
			tle_pkg::C_J_LE_CUR:   take = flags.j_le_cur;
			default:               take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= tle_pkg::P_IDLE;
		end else if (load) begin
			pc_q <= tle_pkg::P_DISP;
		end else if (step) begin
			if (ctl.fin)
				pc_q <= tle_pkg::P_IDLE;
			else if (take)
				pc_q <= ctl.target;
			else
				pc_q <= pc_q + tle_pkg::PC_W'(1);
		end
	end

	tle_dp #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.rx_byte   (s_tdata),
		.step      (step),
		.ctl       (ctl),
		.flags     (flags),
		.emit_data (emit_data)
	);

	tle_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit_req  (busy && ctl.esrc != tle_pkg::E_NONE),
		.emit_byte (emit_data),
		.emit_chan (ctl.echan),
		.flush     (busy && ctl.fin),
		.stall     (stall),
		.pend_v    (pend_v),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !pend_v)
		else $error("held output byte left behind at end of program");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("sequencer did not start after a transfer");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		stall |-> m_tvalid && !m_tready)
		else $error("sequencer stalled with a free output slot");

endmodule
